>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker module of the deframer.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/spd_pkg.sv
// ---------------------------------------------------------------------------
// spd_pkg
// Types and constants of the sync pattern message deframer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package spd_pkg;

	localparam int unsigned SYNC_BYTES_DEF = 8;

	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SYNC_PATTERN = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD  = CFG_IDX_W'(1);

	localparam logic [63:0] SYNC_PATTERN_RST = 64'd6146850545736025093;
	localparam logic [15:0] MAX_PAYLOAD_RST  = 16'd2000;

	localparam logic [7:0] TYPE_PACKET = 8'd7;
	localparam logic [7:0] TYPE_CONFIG = 8'd6;

	localparam logic [1:0] KIND_PACKET  = 2'd0;
	localparam logic [1:0] KIND_CONFIG  = 2'd1;
	localparam logic [1:0] KIND_UNKNOWN = 2'd2;

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_HEADER  = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_SKIP    = 2'd3
	} phase_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  flag_byte;
		logic [15:0] length;
		logic [7:0]  payload_byte;
		logic        data_valid;
		logic        discarded;
		logic        last;
	} result_t;

endpackage

>>> rtl/spd_rx_if.sv
// ---------------------------------------------------------------------------
// spd_rx_if
// Received byte channel with valid/ready handshake.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface spd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> rtl/spd_res_if.sv
// ---------------------------------------------------------------------------
// spd_res_if
// Result channel of the deframer with valid/ready handshake.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface spd_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  flag_byte;
	logic [15:0] length;
	logic [7:0]  payload_byte;
	logic        data_valid;
	logic        discarded;
	logic        last;

	modport source (output valid, output kind, output flag_byte, output length,
		output payload_byte, output data_valid, output discarded, output last,
		input ready);
	modport sink   (input valid, input kind, input flag_byte, input length,
		input payload_byte, input data_valid, input discarded, input last,
		output ready);
endinterface

>>> rtl/spd_cfg_if.sv
// ---------------------------------------------------------------------------
// spd_cfg_if
// Register write channel: register index and write data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface spd_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [spd_pkg::CFG_IDX_W-1:0]  index;
	logic [63:0]                    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/sync_pattern_message_deframer_core.sv
// ---------------------------------------------------------------------------
// sync_pattern_message_deframer_core
// Hunts for a sync pattern in a byte stream, parses the 4-byte header and
// passes payload bytes on, one result per byte, or skips oversized messages.
// ---------------------------------------------------------------------------
// Throughput is one received byte per clock while the input does not stall.
// A byte is registered on acceptance and then processed by the parser
// state, whose result lands in an output register that offers it to the
// sink. The input stalls only while the output register holds a result
// that the sink has not taken and the byte in the input register would
// produce another. Register writes are always accepted and must be
// issued while the block is idle.
`timescale 1ns / 1ps

module sync_pattern_message_deframer_core #(
	parameter int unsigned SYNC_BYTES = spd_pkg::SYNC_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	spd_rx_if.sink        rx,
	spd_res_if.source     res,
	spd_cfg_if.sink       cfg
);

	localparam int unsigned WIN_W  = 8 * SYNC_BYTES;
	localparam int unsigned FILL_W = $clog2(SYNC_BYTES + 1);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(SYNC_BYTES);

	// Configuration registers
	logic [63:0] sync_pattern_q;
	logic [15:0] max_payload_q;

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Parser state
	spd_pkg::phase_t phase_q, phase_d;
	logic [WIN_W-1:0]  window_q, window_d;
	logic [FILL_W-1:0] fill_q, fill_d;
	logic [1:0]        hdr_idx_q, hdr_idx_d;
	logic [1:0]        kind_q, kind_d;
	logic [7:0]        flag_q, flag_d;
	logic [15:0]       size_q, size_d;
	logic [15:0]       remaining_q, remaining_d;

	logic [WIN_W+7:0]  window_wide;
	logic [FILL_W-1:0] fill_inc;
	logic [15:0]       rem_dec;
	logic [15:0]       size_full;

	// Result
	logic              produce;
	spd_pkg::result_t  result_d;
	logic              res_valid_q;
	spd_pkg::result_t  res_q;

	logic advance_s1;
	logic out_free;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_pattern_q <= spd_pkg::SYNC_PATTERN_RST;
			max_payload_q  <= spd_pkg::MAX_PAYLOAD_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				spd_pkg::REG_SYNC_PATTERN: sync_pattern_q <= cfg.data;
				spd_pkg::REG_MAX_PAYLOAD:  max_payload_q  <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

	assign out_free   = !res_valid_q || res.ready;
	assign advance_s1 = valid_s1 && (!produce || out_free);
	assign rx.ready   = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	assign window_wide = {window_q, byte_s1};
	assign fill_inc    = (fill_q < FILL_FULL) ? fill_q + FILL_W'(1) : fill_q;
	assign rem_dec     = remaining_q - 16'd1;
	assign size_full   = {size_q[15:8], byte_s1};

	// Next state of the parser.
	always_comb begin
		phase_d     = phase_q;
		window_d    = window_q;
		fill_d      = fill_q;
		hdr_idx_d   = hdr_idx_q;
		kind_d      = kind_q;
		flag_d      = flag_q;
		size_d      = size_q;
		remaining_d = remaining_q;
		unique case (phase_q)
			spd_pkg::PH_HUNT: begin
				window_d = window_wide[WIN_W-1:0];
				fill_d   = fill_inc;
				if (fill_inc == FILL_FULL && window_d == sync_pattern_q[WIN_W-1:0]) begin
					fill_d    = '0;
					hdr_idx_d = 2'd0;
					phase_d   = spd_pkg::PH_HEADER;
				end
			end
			spd_pkg::PH_HEADER: begin
				hdr_idx_d = hdr_idx_q + 2'd1;
				unique case (hdr_idx_q)
					2'd0: begin
						if (byte_s1 == spd_pkg::TYPE_PACKET) begin
							kind_d = spd_pkg::KIND_PACKET;
						end else if (byte_s1 == spd_pkg::TYPE_CONFIG) begin
							kind_d = spd_pkg::KIND_CONFIG;
						end else begin
							kind_d = spd_pkg::KIND_UNKNOWN;
						end
					end
					2'd1: flag_d = byte_s1;
					2'd2: size_d = {byte_s1, 8'd0};
					default: begin
						size_d      = size_full;
						remaining_d = size_full;
						if (size_full == 16'd0) begin
							phase_d = spd_pkg::PH_HUNT;
						end else if (size_full > max_payload_q) begin
							phase_d = spd_pkg::PH_SKIP;
						end else begin
							phase_d = spd_pkg::PH_PAYLOAD;
						end
					end
				endcase
			end
			spd_pkg::PH_PAYLOAD, spd_pkg::PH_SKIP: begin
				remaining_d = rem_dec;
				if (rem_dec == 16'd0) begin
					phase_d = spd_pkg::PH_HUNT;
				end
			end
			default: ;
		endcase
	end

	// Result of the byte in the input register.
	always_comb begin
		produce               = 1'b0;
		result_d.kind         = kind_d;
		result_d.flag_byte    = flag_d;
		result_d.length       = size_d;
		result_d.payload_byte = 8'd0;
		result_d.data_valid   = 1'b0;
		result_d.discarded    = 1'b0;
		result_d.last         = 1'b0;
		unique case (phase_q)
			spd_pkg::PH_HEADER: begin
				if (hdr_idx_q == 2'd3 && size_full == 16'd0) begin
					produce       = 1'b1;
					result_d.last = 1'b1;
				end
			end
			spd_pkg::PH_PAYLOAD: begin
				produce               = 1'b1;
				result_d.payload_byte = byte_s1;
				result_d.data_valid   = 1'b1;
				result_d.last         = (rem_dec == 16'd0);
			end
			spd_pkg::PH_SKIP: begin
				if (rem_dec == 16'd0) begin
					produce            = 1'b1;
					result_d.discarded = 1'b1;
					result_d.last      = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= spd_pkg::PH_HUNT;
			window_q    <= '0;
			fill_q      <= '0;
			hdr_idx_q   <= 2'd0;
			kind_q      <= 2'd0;
			flag_q      <= 8'd0;
			size_q      <= 16'd0;
			remaining_q <= 16'd0;
		end else if (advance_s1) begin
			phase_q     <= phase_d;
			window_q    <= window_d;
			fill_q      <= fill_d;
			hdr_idx_q   <= hdr_idx_d;
			kind_q      <= kind_d;
			flag_q      <= flag_d;
			size_q      <= size_d;
			remaining_q <= remaining_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance_s1 && produce) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && produce) begin
			res_q <= result_d;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.kind         = res_q.kind;
	assign res.flag_byte    = res_q.flag_byte;
	assign res.length       = res_q.length;
	assign res.payload_byte = res_q.payload_byte;
	assign res.data_valid   = res_q.data_valid;
	assign res.discarded    = res_q.discarded;
	assign res.last         = res_q.last;

endmodule

>>> rtl/spd_checker.sv
// ---------------------------------------------------------------------------
// spd_checker
// Port-level checks on the deframer result channel, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [7:0]  res_payload_byte,
	input logic        res_data_valid,
	input logic        res_discarded,
	input logic        res_last
);

	// A stalled beat stays offered and its payload byte unchanged.
	`ASSERT_NEXT(a_valid_held, clk, arst_n, res_valid && !res_ready, res_valid)
	`ASSERT_NEXT(a_byte_held, clk, arst_n, res_valid && !res_ready, $stable(res_payload_byte))

	// A skipped message never carries payload data.
	`ASSERT_IMP(a_disc_no_data, clk, arst_n, res_valid && res_discarded, !res_data_valid)
	// Every beat without payload closes its message.
	`ASSERT_IMP(a_empty_is_last, clk, arst_n, res_valid && !res_data_valid, res_last)
	// Beats without payload carry a zero byte.
	`ASSERT_IMP(a_empty_zero, clk, arst_n, res_valid && !res_data_valid,
		res_payload_byte == 8'd0)

endmodule

bind sync_pattern_message_deframer_core spd_checker u_spd_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_payload_byte (res.payload_byte),
	.res_data_valid   (res.data_valid),
	.res_discarded    (res.discarded),
	.res_last         (res.last)
);
